### rtl/msed_pkg.sv
// Package for the music sequence event decoder.
// Holds opcode codes, event kinds, field widths and the command record that
// the front part hands to the back part. No dependencies.
`default_nettype none

package msed_pkg;

    // Default sizes of the stores.
    localparam int unsigned LOOP_DEPTH_DEF  = 4;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Opcode codes and ranges.
    localparam logic [7:0] OP_REST_NEW     = 8'h00;
    localparam logic [7:0] OP_FULL_FIRST   = 8'h01;
    localparam logic [7:0] OP_FULL_LAST    = 8'h7f;
    localparam logic [7:0] OP_REST_HELD    = 8'h80;
    localparam logic [7:0] OP_SHORT_FIRST  = 8'h81;
    localparam logic [7:0] OP_SHORT_LAST   = 8'hf4;
    localparam logic [7:0] OP_ECHO         = 8'hf5;
    localparam logic [7:0] OP_IGNORE_A     = 8'hf6;
    localparam logic [7:0] OP_IGNORE_B     = 8'hf7;
    localparam logic [7:0] OP_LOOP_END     = 8'hf8;
    localparam logic [7:0] OP_LOOP_START   = 8'hf9;
    localparam logic [7:0] OP_PAN          = 8'hfa;
    localparam logic [7:0] OP_TEMPO        = 8'hfb;
    localparam logic [7:0] OP_PROGRAM      = 8'hfc;
    localparam logic [7:0] OP_TUNING       = 8'hfd;
    localparam logic [7:0] OP_END          = 8'hfe;
    localparam logic [7:0] OP_BAD          = 8'hff;

    // Program number that selects percussion.
    localparam logic [7:0] PERC_PROGRAM = 8'h7f;

    // Command lengths in bytes.
    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    typedef enum logic [3:0] {
        KIND_NOTE         = 4'd0,
        KIND_REST         = 4'd1,
        KIND_ECHO         = 4'd2,
        KIND_IGNORED      = 4'd3,
        KIND_LOOP_START   = 4'd4,
        KIND_LOOP_END     = 4'd5,
        KIND_LOOP_FOREVER = 4'd6,
        KIND_PAN          = 4'd7,
        KIND_TEMPO        = 4'd8,
        KIND_PROGRAM      = 4'd9,
        KIND_TUNING       = 4'd10,
        KIND_END          = 4'd11,
        KIND_BAD          = 4'd12
    } t_kind;

    // One classified command, as queued between front and back.
    typedef struct packed {
        t_kind       kind;
        logic [6:0]  key;
        logic [7:0]  arg;        // argument byte reported on the output
        logic [7:0]  a1;
        logic [7:0]  a2;
        logic [7:0]  a3;
        logic [2:0]  len;
        logic [15:0] addr;
        logic [16:0] next_seq;   // address after the command, with carry
        logic        load_rest;  // rest that brings a new duration
        logic        load_note;  // note that brings step, duration, velocity
        logic        go_base;    // keep going unless the address overflows
    } t_cmd;

endpackage

`default_nettype wire

### rtl/music_sequence_event_decoder_top.sv
// Top level of the music sequence event decoder.
// Depends on msed_pkg, msed_front, msed_queue and msed_back.
`default_nettype none

// Channel   Direction  Handshake             Payload
// command   in         i_valid / o_ready     address, opcode byte, three following bytes
// event     out        o_valid / i_ready     kind, note fields, argument, length, next address,
//                                            keep going, percussion flag
//
// A command is decoded at the beat that accepts it and enters the queue in that
// cycle; the back part takes it from the queue when its result register is free and
// registers the result. With the default queue depth one command per cycle is sustained
// while i_ready stays high; the rate is set by the back part, which updates its state on every take.
// Synchronous active-low reset clears the held note values, the loop level, the
// loop count stack, the percussion flag, the queue and the result valid bit.
// A stalled result holds in the output register while the queue keeps taking
// commands until it is full, after which o_ready drops.

module music_sequence_event_decoder_top
    import msed_pkg::*;
#(
    parameter int unsigned LOOP_DEPTH  = LOOP_DEPTH_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_event_address,
    input  wire logic [7:0]  i_op_byte,
    input  wire logic [7:0]  i_arg_first,
    input  wire logic [7:0]  i_arg_second,
    input  wire logic [7:0]  i_arg_third,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_event_kind,
    output logic [6:0]       o_note_key,
    output logic [7:0]       o_note_velocity,
    output logic [7:0]       o_note_duration,
    output logic [7:0]       o_time_advance,
    output logic [7:0]       o_arg_value,
    output logic [2:0]       o_event_length,
    output logic [15:0]      o_next_address,
    output logic             o_keep_going,
    output logic             o_percussion_on
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;

    // The front part is stateless: it classifies the command on the input
    // ports and the queue captures the record on the accepting beat.
    msed_front u_front (
        .i_event_address (i_event_address),
        .i_op_byte       (i_op_byte),
        .i_arg_first     (i_arg_first),
        .i_arg_second    (i_arg_second),
        .i_arg_third     (i_arg_third),
        .o_cmd           (front_cmd)
    );

    assign o_ready = !queue_full;

    msed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_valid),
        .i_push_data (front_cmd),
        .o_full      (queue_full),
        .i_pop       (queue_pop),
        .o_pop_valid (queue_valid),
        .o_pop_data  (queue_cmd)
    );

    // The back part owns all state that carries from one command to the next,
    // so commands are executed strictly in order.
    msed_back #(
        .LOOP_DEPTH (LOOP_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (queue_valid),
        .i_cmd           (queue_cmd),
        .o_cmd_pop       (queue_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_event_kind    (o_event_kind),
        .o_note_key      (o_note_key),
        .o_note_velocity (o_note_velocity),
        .o_note_duration (o_note_duration),
        .o_time_advance  (o_time_advance),
        .o_arg_value     (o_arg_value),
        .o_event_length  (o_event_length),
        .o_next_address  (o_next_address),
        .o_keep_going    (o_keep_going),
        .o_percussion_on (o_percussion_on)
    );

endmodule

`default_nettype wire

### rtl/msed_front.sv
// Front part of the music sequence event decoder: classifies one command.
// Depends on msed_pkg for opcodes, kinds and the command record.
`default_nettype none

module msed_front
    import msed_pkg::*;
(
    input  wire logic [15:0] i_event_address,
    input  wire logic [7:0]  i_op_byte,
    input  wire logic [7:0]  i_arg_first,
    input  wire logic [7:0]  i_arg_second,
    input  wire logic [7:0]  i_arg_third,
    output t_cmd             o_cmd
);

    t_kind      kind;
    logic [7:0] arg;
    logic [2:0] len;
    logic       load_rest;
    logic       load_note;
    logic       go_base;

    always_comb begin
        kind      = KIND_BAD;
        arg       = '0;
        len       = LEN_ONE;
        load_rest = 1'b0;
        load_note = 1'b0;
        go_base   = 1'b1;
        unique case (i_op_byte) inside
            OP_REST_NEW: begin
                kind      = KIND_REST;
                len       = LEN_TWO;
                load_rest = 1'b1;
            end
            OP_REST_HELD: begin
                kind = KIND_REST;
            end
            [OP_FULL_FIRST:OP_FULL_LAST]: begin
                kind      = KIND_NOTE;
                len       = LEN_FOUR;
                load_note = 1'b1;
            end
            [OP_SHORT_FIRST:OP_SHORT_LAST]: begin
                kind = KIND_NOTE;
            end
            OP_ECHO: begin
                kind = KIND_ECHO;
                arg  = i_arg_first;
                len  = LEN_TWO;
            end
            OP_IGNORE_A, OP_IGNORE_B: begin
                kind = KIND_IGNORED;
                arg  = i_arg_first;
                len  = LEN_TWO;
            end
            OP_LOOP_END: begin
                arg = i_arg_first;
                len = LEN_TWO;
                // A zero count means the loop never ends and the track halts.
                if (i_arg_first == 8'd0) begin
                    kind    = KIND_LOOP_FOREVER;
                    go_base = 1'b0;
                end else begin
                    kind = KIND_LOOP_END;
                end
            end
            OP_LOOP_START: begin
                kind = KIND_LOOP_START;
            end
            OP_PAN: begin
                kind = KIND_PAN;
                arg  = i_arg_first;
                len  = LEN_TWO;
            end
            OP_TEMPO: begin
                kind = KIND_TEMPO;
                arg  = i_arg_first;
                len  = LEN_TWO;
            end
            OP_PROGRAM: begin
                kind = KIND_PROGRAM;
                arg  = i_arg_first;
                len  = LEN_TWO;
            end
            OP_TUNING: begin
                kind = KIND_TUNING;
                arg  = i_arg_first;
                len  = LEN_TWO;
            end
            OP_END: begin
                kind    = KIND_END;
                go_base = 1'b0;
            end
            OP_BAD: begin
                kind    = KIND_BAD;
                go_base = 1'b0;
            end
            default: begin
                kind    = KIND_BAD;
                go_base = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_cmd.kind      = kind;
        o_cmd.key       = (kind == KIND_NOTE) ? i_op_byte[6:0] : 7'd0;
        o_cmd.arg       = arg;
        o_cmd.a1        = i_arg_first;
        o_cmd.a2        = i_arg_second;
        o_cmd.a3        = i_arg_third;
        o_cmd.len       = len;
        o_cmd.addr      = i_event_address;
        o_cmd.next_seq  = {1'b0, i_event_address} + {14'd0, len};
        o_cmd.load_rest = load_rest;
        o_cmd.load_note = load_note;
        o_cmd.go_base   = go_base;
    end

endmodule

`default_nettype wire

### rtl/msed_queue.sv
// Short first-in first-out queue of classified commands between front and back.
// Depends on msed_pkg for the command record.
`default_nettype none

module msed_queue
    import msed_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_push_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_pop_valid,
    output t_cmd      o_pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full      = (r_count == CNT_FULL);
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_ONE;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_ONE;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_ONE;
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/msed_back.sv
// Back part of the music sequence event decoder: applies held note values,
// the loop stacks and the percussion flag, and holds the result register.
// Depends on msed_pkg for kinds and the command record.
`default_nettype none

module msed_back
    import msed_pkg::*;
#(
    parameter int unsigned LOOP_DEPTH = LOOP_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  wire t_cmd        i_cmd,
    output logic             o_cmd_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_event_kind,
    output logic [6:0]       o_note_key,
    output logic [7:0]       o_note_velocity,
    output logic [7:0]       o_note_duration,
    output logic [7:0]       o_time_advance,
    output logic [7:0]       o_arg_value,
    output logic [2:0]       o_event_length,
    output logic [15:0]      o_next_address,
    output logic             o_keep_going,
    output logic             o_percussion_on
);

    localparam int unsigned LVL_W = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LOOP_DEPTH - 1);
    localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);

    // Held state.
    logic [7:0]       r_dur, n_dur;
    logic [7:0]       r_vel, n_vel;
    logic [7:0]       r_step, n_step;
    logic             r_perc, n_perc;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic [15:0]      r_ret [LOOP_DEPTH];
    logic [7:0]       r_cnt [LOOP_DEPTH];

    // Result register.
    logic             r_out_valid;
    logic [3:0]       r_kind;
    logic [6:0]       r_key;
    logic [7:0]       r_vel_out;
    logic [7:0]       r_dur_out;
    logic [7:0]       r_adv;
    logic [7:0]       r_arg;
    logic [2:0]       r_len;
    logic [15:0]      r_next;
    logic             r_go;

    logic [LVL_W-1:0] prev;
    logic [LVL_W-1:0] lvl_up;
    logic [7:0]       cnt_loaded;
    logic [7:0]       cnt_dec;
    logic [7:0]       cnt_new;
    logic             cnt_wr;
    logic             ret_wr;
    logic             jump;
    logic [7:0]       vel_out;
    logic [7:0]       dur_out;
    logic [7:0]       adv;
    logic [15:0]      next_addr;
    logic             go;
    logic             take;

    assign take      = i_cmd_valid && (!r_out_valid || i_ready);
    assign o_cmd_pop = take;

    assign prev       = (r_lvl == '0) ? LVL_LAST : r_lvl - LVL_ONE;
    assign lvl_up     = (r_lvl == LVL_LAST) ? '0 : r_lvl + LVL_ONE;
    assign cnt_loaded = (r_cnt[prev] == 8'd0) ? i_cmd.a1 : r_cnt[prev];
    assign cnt_dec    = cnt_loaded - 8'd1;

    always_comb begin
        n_dur   = r_dur;
        n_vel   = r_vel;
        n_step  = r_step;
        n_perc  = r_perc;
        n_lvl   = r_lvl;
        cnt_wr  = 1'b0;
        cnt_new = cnt_loaded;
        ret_wr  = 1'b0;
        jump    = 1'b0;
        vel_out = '0;
        dur_out = '0;
        adv     = '0;
        unique case (i_cmd.kind)
            KIND_REST: begin
                if (i_cmd.load_rest) begin
                    n_dur = i_cmd.a1;
                end
                dur_out = n_dur;
                adv     = n_dur;
            end
            KIND_NOTE: begin
                if (i_cmd.load_note) begin
                    n_step = i_cmd.a1;
                    n_dur  = i_cmd.a2 - 8'd1;
                    n_vel  = i_cmd.a3;
                end
                vel_out = n_vel;
                dur_out = n_dur;
                adv     = n_step;
            end
            KIND_LOOP_FOREVER: begin
                cnt_wr  = 1'b1;
                cnt_new = cnt_loaded;
            end
            KIND_LOOP_END: begin
                cnt_wr  = 1'b1;
                cnt_new = cnt_dec;
                if (cnt_dec != 8'd0) begin
                    jump = 1'b1;
                end else begin
                    n_lvl = prev;
                end
            end
            KIND_LOOP_START: begin
                ret_wr = 1'b1;
                n_lvl  = lvl_up;
            end
            KIND_PROGRAM: begin
                n_perc = (i_cmd.a1 == PERC_PROGRAM);
            end
            default: begin
            end
        endcase
        // A jump target is 16 bits and cannot overflow; the sequential
        // address can run past the top of memory.
        next_addr = jump ? r_ret[prev] : i_cmd.next_seq[15:0];
        go        = i_cmd.go_base && (jump || !i_cmd.next_seq[16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur       <= '0;
            r_vel       <= '0;
            r_step      <= '0;
            r_perc      <= 1'b0;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LOOP_DEPTH; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (take) begin
                r_dur  <= n_dur;
                r_vel  <= n_vel;
                r_step <= n_step;
                r_perc <= n_perc;
                r_lvl  <= n_lvl;
                if (cnt_wr) begin
                    r_cnt[prev] <= cnt_new;
                end
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && ret_wr) begin
            r_ret[r_lvl] <= i_cmd.addr + 16'd1;
        end
        if (take) begin
            r_kind    <= i_cmd.kind;
            r_key     <= i_cmd.key;
            r_vel_out <= vel_out;
            r_dur_out <= dur_out;
            r_adv     <= adv;
            r_arg     <= i_cmd.arg;
            r_len     <= i_cmd.len;
            r_next    <= next_addr;
            r_go      <= go;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_event_kind    = r_kind;
    assign o_note_key      = r_key;
    assign o_note_velocity = r_vel_out;
    assign o_note_duration = r_dur_out;
    assign o_time_advance  = r_adv;
    assign o_arg_value     = r_arg;
    assign o_event_length  = r_len;
    assign o_next_address  = r_next;
    assign o_keep_going    = r_go;
    // The percussion flag of the result is the flag after its command.
    assign o_percussion_on = r_perc;

endmodule

`default_nettype wire
